// ===== hdl/ppp_pkg.sv =====
// Shared constants, types and helpers of the pinhole point projection block.
package ppp_pkg;

  // Fixed field widths.
  localparam int unsigned COORD_W_DEF   = 21;
  localparam int unsigned FRAC_BITS_DEF = 4;
  localparam int unsigned POS_W         = 21;
  localparam int unsigned BASIS_W       = 16;
  localparam int unsigned POS_REG_W     = 3 * POS_W;
  localparam int unsigned BASIS_REG_W   = 3 * BASIS_W;
  localparam int unsigned FOCAL_W       = 16;
  localparam int unsigned SIZE_W        = 14;
  localparam int unsigned SCREEN_W      = 21;
  localparam int unsigned DIST_W        = 22;

  // The quotient is only needed up to the point where the screen value
  // saturates whatever the centre; it matches the root width, so the divider
  // and the square root have the same latency.
  localparam int unsigned QUOT_BITS = DIST_W;
  localparam int unsigned PIPE_LAT  = QUOT_BITS + 2;
  localparam int unsigned SUM_W     = QUOT_BITS + 4;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = POS_REG_W;

  localparam logic [CFG_IDX_W-1:0] REG_CAM_POSITION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_FORWARD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_RIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_UP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LENGTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd6;

  localparam logic [BASIS_REG_W-1:0] FORWARD_RST = 48'h4000_0000_0000;
  localparam logic [BASIS_REG_W-1:0] RIGHT_RST   = 48'h0000_0000_4000;
  localparam logic [BASIS_REG_W-1:0] UP_RST      = 48'h0000_4000_0000;
  localparam logic [FOCAL_W-1:0]     FOCAL_RST   = 16'd8000;
  localparam logic [SIZE_W-1:0]      WIDTH_RST   = 14'd800;
  localparam logic [SIZE_W-1:0]      HEIGHT_RST  = 14'd450;

  typedef struct packed {
    logic in_view;
    logic zero;
    logic x_neg;
    logic y_neg;
  } ppp_flags_t;

  // Clamps a wide signed sum to the signed screen range.
  function automatic logic [SCREEN_W-1:0] sat_screen(input logic [SUM_W-1:0] v);
    logic [SUM_W-SCREEN_W:0] top;
    top = v[SUM_W-1:SCREEN_W-1];
    if (top == '0 || top == '1) begin
      return v[SCREEN_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(SCREEN_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SCREEN_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hdl/ppp_fifo.sv =====
// Small register queue with fall-through read data.
module ppp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);
  localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTRW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_en ? ((wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = rd_en ? ((rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CNTW'(wr_en) - CNTW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(DEPTH))
    else $error("queue holds more words than it has entries");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && empty_o && !push_i) |=> (cnt_q == '0))
    else $error("pop of an empty queue changed its fill");

endmodule

// ===== hdl/ppp_front.sv =====
// Front end: camera-space offset, basis products, dot sums, squared length and classification.
module ppp_front #(
  parameter int unsigned COORD_WIDTH = 21,
  parameter int unsigned LW          = 22,
  parameter int unsigned MAGW        = 38,
  parameter int unsigned SQW         = 46
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic signed [COORD_WIDTH-1:0]     point_x_i,
  input  logic signed [COORD_WIDTH-1:0]     point_y_i,
  input  logic signed [COORD_WIDTH-1:0]     point_z_i,
  input  logic [ppp_pkg::POS_REG_W-1:0]     cam_position_i,
  input  logic [ppp_pkg::BASIS_REG_W-1:0]   cam_forward_i,
  input  logic [ppp_pkg::BASIS_REG_W-1:0]   cam_right_i,
  input  logic [ppp_pkg::BASIS_REG_W-1:0]   cam_up_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [MAGW-1:0]                   depth_mag_o,
  output logic [MAGW-1:0]                   x_mag_o,
  output logic [MAGW-1:0]                   y_mag_o,
  output logic [SQW-1:0]                    sq_o,
  output ppp_pkg::ppp_flags_t               flags_o
);
  import ppp_pkg::*;

  localparam int unsigned PW   = LW + BASIS_W;
  localparam int unsigned DOTW = LW + 17;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [COORD_WIDTH-1:0] pt    [3];
  logic signed [POS_W-1:0]       cpos  [3];
  logic signed [LW-1:0]          loc_d [3];
  logic signed [LW-1:0]          loc_q [3];
  logic [LW-1:0]                 lmag  [3];
  logic signed [PW-1:0]          pf_q  [3];
  logic signed [PW-1:0]          pr_q  [3];
  logic signed [PW-1:0]          pu_q  [3];
  logic [2*LW-1:0]               psq_q [3];

  logic signed [DOTW-1:0] dep_q, dr_q, du_q;
  logic [SQW-1:0]         sq3_q;
  logic [DOTW-1:0]        dep_abs, dr_abs, du_abs;

  logic [MAGW-1:0] depth_mag_q, x_mag_q, y_mag_q;
  logic [SQW-1:0]  sq_q;
  ppp_flags_t      flags_d, flags_q;

  assign en     = !v4_q || ready_i;
  assign full_o = !en;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cpos[i]  = $signed(cam_position_i[POS_W*i +: POS_W]);
      loc_d[i] = LW'(pt[i]) - LW'(cpos[i]);
      lmag[i]  = loc_q[i][LW-1] ? LW'(-loc_q[i]) : LW'(loc_q[i]);
    end
  end

  always_comb begin
    dep_abs = dep_q[DOTW-1] ? DOTW'(-dep_q) : DOTW'(dep_q);
    dr_abs  = dr_q[DOTW-1]  ? DOTW'(-dr_q)  : DOTW'(dr_q);
    du_abs  = du_q[DOTW-1]  ? DOTW'(-du_q)  : DOTW'(du_q);
    flags_d.in_view = !dep_q[DOTW-1] && (dep_q != '0);
    flags_d.zero    = (dep_q == '0);
    // Screen x uses the negated right product, so it is negative when dr is positive.
    flags_d.x_neg   = (!dr_q[DOTW-1] && (dr_q != '0)) ^ dep_q[DOTW-1];
    flags_d.y_neg   = du_q[DOTW-1] ^ dep_q[DOTW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        loc_q[i] <= loc_d[i];
        pf_q[i]  <= loc_q[i] * $signed(cam_forward_i[BASIS_W*i +: BASIS_W]);
        pr_q[i]  <= loc_q[i] * $signed(cam_right_i[BASIS_W*i +: BASIS_W]);
        pu_q[i]  <= loc_q[i] * $signed(cam_up_i[BASIS_W*i +: BASIS_W]);
        psq_q[i] <= lmag[i] * lmag[i];
      end
      dep_q <= DOTW'(pf_q[0]) + DOTW'(pf_q[1]) + DOTW'(pf_q[2]);
      dr_q  <= DOTW'(pr_q[0]) + DOTW'(pr_q[1]) + DOTW'(pr_q[2]);
      du_q  <= DOTW'(pu_q[0]) + DOTW'(pu_q[1]) + DOTW'(pu_q[2]);
      sq3_q <= SQW'(psq_q[0]) + SQW'(psq_q[1]) + SQW'(psq_q[2]);
      depth_mag_q <= dep_abs[MAGW-1:0];
      x_mag_q     <= dr_abs[MAGW-1:0];
      y_mag_q     <= du_abs[MAGW-1:0];
      sq_q        <= sq3_q;
      flags_q     <= flags_d;
    end
  end

  assign valid_o     = v4_q;
  assign depth_mag_o = depth_mag_q;
  assign x_mag_o     = x_mag_q;
  assign y_mag_o     = y_mag_q;
  assign sq_o        = sq_q;
  assign flags_o     = flags_q;

endmodule

// ===== hdl/ppp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, capped quotient.
module ppp_div #(
  parameter int unsigned NW = 58,
  parameter int unsigned DW = 42,
  parameter int unsigned QB = 22
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB:0]   quot_o
);
  logic [DW-1:0] r_q   [QB+2];
  logic [DW-1:0] d_q   [QB+2];
  logic [QB:0]   nl_q  [QB+2];
  logic [QB:0]   qt_q  [QB+2];
  logic          ovf_q [QB+2];
  logic [NW-1:0] num_top;

  assign num_top = num_i >> QB;

  // A quotient that reaches the cap is flagged up front; the rest then fits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= DW'(num_i >> (QB + 1));
      d_q[0]   <= den_i;
      nl_q[0]  <= num_i[QB:0];
      qt_q[0]  <= '0;
      ovf_q[0] <= (num_top >= NW'(den_i));
    end
  end

  for (genvar k = 0; k <= QB; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    assign trial = {r_q[k], nl_q[k][QB-k]};
    assign ge    = (trial >= {1'b0, d_q[k]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge ? DW'(trial - {1'b0, d_q[k]}) : trial[DW-1:0];
        d_q[k+1]   <= d_q[k];
        nl_q[k+1]  <= nl_q[k];
        qt_q[k+1]  <= {qt_q[k][QB-1:0], ge};
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quot_o = ovf_q[QB+1] ? {1'b1, {QB{1'b0}}} : qt_q[QB+1];

endmodule

// ===== hdl/ppp_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, saturated result.
module ppp_sqrt #(
  parameter int unsigned SQW = 46,
  parameter int unsigned RW  = 22
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [SQW-1:0] sq_i,
  output logic [RW-1:0]  root_o
);
  localparam int unsigned RMW = RW + 2;
  localparam int unsigned TW  = RMW + 2;

  logic [RMW-1:0]  rem_q  [RW+1];
  logic [RW-1:0]   root_q [RW+1];
  logic [2*RW-1:0] v_q    [RW+1];
  logic            big_q  [RW+1];
  logic [RW-1:0]   dist_q;

  // Anything at or above the square of the full range saturates.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      v_q[0]    <= sq_i[2*RW-1:0];
      big_q[0]  <= |sq_i[SQW-1:2*RW];
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [TW-1:0] cur, trial;
    logic          ge;
    assign cur   = {rem_q[k], v_q[k][2*(RW-1-k)+1 -: 2]};
    assign trial = TW'({root_q[k], 2'b01});
    assign ge    = (cur >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? RMW'(cur - trial) : cur[RMW-1:0];
        root_q[k+1] <= {root_q[k][RW-2:0], ge};
        v_q[k+1]    <= v_q[k];
        big_q[k+1]  <= big_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= big_q[RW] ? '1 : root_q[RW];
    end
  end

  assign root_o = dist_q;

endmodule

// ===== hdl/ppp_back.sv =====
// Back end: focal scaling, perspective divide, distance root and screen offset.
module ppp_back #(
  parameter int unsigned MAGW = 38,
  parameter int unsigned SQW  = 46,
  parameter int unsigned FRAC = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_pop_o,
  input  logic [MAGW-1:0]                     depth_mag_i,
  input  logic [MAGW-1:0]                     x_mag_i,
  input  logic [MAGW-1:0]                     y_mag_i,
  input  logic [SQW-1:0]                      sq_i,
  input  ppp_pkg::ppp_flags_t                 flags_i,
  input  logic [ppp_pkg::FOCAL_W-1:0]         focal_i,
  input  logic [ppp_pkg::SIZE_W-1:0]          width_i,
  input  logic [ppp_pkg::SIZE_W-1:0]          height_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ppp_pkg::SCREEN_W-1:0]        screen_x_o,
  output logic [ppp_pkg::SCREEN_W-1:0]        screen_y_o,
  output logic [ppp_pkg::DIST_W-1:0]          distance_o,
  output logic                                in_view_o
);
  import ppp_pkg::*;

  localparam int unsigned LOW  = (MAGW + 1) / 2;
  localparam int unsigned HIW  = MAGW - LOW;
  localparam int unsigned NW   = MAGW + FOCAL_W + FRAC;
  localparam int unsigned DW   = MAGW + 4;
  localparam int unsigned CENW = SIZE_W - 1 + FRAC;

  logic en;

  // Stage one: focal length partial products.
  logic                    v1_q;
  logic [LOW+FOCAL_W-1:0]  xlo_q, ylo_q;
  logic [HIW+FOCAL_W-1:0]  xhi_q, yhi_q;
  logic [MAGW-1:0]         d1_q;
  logic [SQW-1:0]          sq1_q;
  ppp_flags_t              f1_q;

  // Stage two: dividends and divisor.
  logic            v2_q;
  logic [NW-1:0]   nx_q, ny_q;
  logic [DW-1:0]   d2_q;
  logic [SQW-1:0]  sq2_q;
  ppp_flags_t      f2_q;

  logic       vl_q [PIPE_LAT];
  ppp_flags_t fl_q [PIPE_LAT];

  logic [QUOT_BITS:0] qx, qy;
  logic [DIST_W-1:0]  root;
  logic [CENW-1:0]    cen_x, cen_y;
  logic [SUM_W-1:0]   sum_x, sum_y;
  ppp_flags_t         fin;

  logic                vo_q;
  logic [SCREEN_W-1:0] sx_q, sy_q;
  logic [DIST_W-1:0]   dist_q;
  logic                view_q;

  assign en       = !vo_q || out_ready_i;
  assign in_pop_o = en && in_valid_i;

  ppp_div #(.NW(NW), .DW(DW), .QB(QUOT_BITS)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (nx_q),
    .den_i  (d2_q),
    .quot_o (qx)
  );

  ppp_div #(.NW(NW), .DW(DW), .QB(QUOT_BITS)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (ny_q),
    .den_i  (d2_q),
    .quot_o (qy)
  );

  ppp_sqrt #(.SQW(SQW), .RW(DIST_W)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sq_i   (sq2_q),
    .root_o (root)
  );

  always_comb begin
    fin   = fl_q[PIPE_LAT-1];
    cen_x = CENW'(width_i[SIZE_W-1:1]) << FRAC;
    cen_y = CENW'(height_i[SIZE_W-1:1]) << FRAC;
    sum_x = SUM_W'(cen_x);
    sum_y = SUM_W'(cen_y);
    // Zero depth leaves the point at the screen centre.
    if (!fin.zero) begin
      sum_x = fin.x_neg ? sum_x - SUM_W'(qx) : sum_x + SUM_W'(qx);
      sum_y = fin.y_neg ? sum_y - SUM_W'(qy) : sum_y + SUM_W'(qy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
      for (int i = 0; i < PIPE_LAT; i++) begin
        vl_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      vl_q[0] <= v2_q;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vl_q[i] <= vl_q[i-1];
      end
      vo_q <= vl_q[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xlo_q <= x_mag_i[LOW-1:0] * focal_i;
      xhi_q <= x_mag_i[MAGW-1:LOW] * focal_i;
      ylo_q <= y_mag_i[LOW-1:0] * focal_i;
      yhi_q <= y_mag_i[MAGW-1:LOW] * focal_i;
      d1_q  <= depth_mag_i;
      sq1_q <= sq_i;
      f1_q  <= flags_i;

      nx_q  <= (NW'(xhi_q) << (LOW + FRAC)) + (NW'(xlo_q) << FRAC);
      ny_q  <= (NW'(yhi_q) << (LOW + FRAC)) + (NW'(ylo_q) << FRAC);
      d2_q  <= {d1_q, 4'b0000};
      sq2_q <= sq1_q;
      f2_q  <= f1_q;

      fl_q[0] <= f2_q;
      for (int i = 1; i < PIPE_LAT; i++) begin
        fl_q[i] <= fl_q[i-1];
      end

      sx_q   <= sat_screen(sum_x);
      sy_q   <= sat_screen(sum_y);
      dist_q <= root;
      view_q <= fin.in_view;
    end
  end

  assign out_valid_o = vo_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign distance_o  = dist_q;
  assign in_view_o   = view_q;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !out_ready_i) |=> (vo_q && $stable(sx_q) && $stable(dist_q)))
    else $error("finished word changed while the result queue was full");

endmodule

// ===== hdl/pinhole_point_projection.sv =====
// Top level of the pinhole point projection: configuration, front, queues, back.
//
//  channel  | direction | handshake           | word
//  ---------+-----------+---------------------+-----------------------------------
//  point    | in        | push / full         | point_x_i, point_y_i, point_z_i
//  result   | out       | empty / pop         | screen_x_o, screen_y_o, distance_o,
//           |           |                     | in_view_o
//  config   | in        | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// One point is taken in every cycle while full is low; the two pipelined dividers and
// the pipelined square root each start one word a cycle while the back is not stalled.
// A point passes the front stages, the middle queue and the back stages before it reaches
// the result queue, and the result ports show it from the edge that writes it there.
// Reset loads the default camera and empties both pipelines and queues; no
// clearing pass follows. Front and back stall independently: the front halts
// only while the middle queue is full, the back only while the result queue is.
module pinhole_point_projection #(
  parameter int unsigned COORD_WIDTH      = ppp_pkg::COORD_W_DEF,
  parameter int unsigned SCREEN_FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [COORD_WIDTH-1:0]        point_x_i,
  input  logic signed [COORD_WIDTH-1:0]        point_y_i,
  input  logic signed [COORD_WIDTH-1:0]        point_z_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [ppp_pkg::SCREEN_W-1:0]  screen_x_o,
  output logic signed [ppp_pkg::SCREEN_W-1:0]  screen_y_o,
  output logic [ppp_pkg::DIST_W-1:0]           distance_o,
  output logic                                 in_view_o,
  input  logic                                 cfg_we_i,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ppp_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import ppp_pkg::*;

  localparam int unsigned LW   = ((COORD_WIDTH > POS_W) ? COORD_WIDTH : POS_W) + 1;
  localparam int unsigned MAGW = LW + 16;
  localparam int unsigned SQW  = 2 * LW + 2;
  localparam int unsigned FLW  = $bits(ppp_flags_t);
  localparam int unsigned MIDW = 3 * MAGW + SQW + FLW;
  localparam int unsigned OUTW = 2 * SCREEN_W + DIST_W + 1;

  logic [POS_REG_W-1:0]   cam_position_q;
  logic [BASIS_REG_W-1:0] cam_forward_q, cam_right_q, cam_up_q;
  logic [FOCAL_W-1:0]     focal_q;
  logic [SIZE_W-1:0]      width_q, height_q;

  logic            fr_valid, mid_full, mid_empty, mid_pop;
  logic [MAGW-1:0] fr_depth, fr_x, fr_y;
  logic [SQW-1:0]  fr_sq;
  ppp_flags_t      fr_flags;
  logic [MIDW-1:0] mid_wdata, mid_rdata;

  logic                bk_valid, out_full;
  logic [SCREEN_W-1:0] bk_sx, bk_sy;
  logic [DIST_W-1:0]   bk_dist;
  logic                bk_view;
  logic [OUTW-1:0]     out_wdata, out_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_position_q <= '0;
      cam_forward_q  <= FORWARD_RST;
      cam_right_q    <= RIGHT_RST;
      cam_up_q       <= UP_RST;
      focal_q        <= FOCAL_RST;
      width_q        <= WIDTH_RST;
      height_q       <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CAM_POSITION:  cam_position_q <= cfg_data_i[POS_REG_W-1:0];
        REG_CAM_FORWARD:   cam_forward_q  <= cfg_data_i[BASIS_REG_W-1:0];
        REG_CAM_RIGHT:     cam_right_q    <= cfg_data_i[BASIS_REG_W-1:0];
        REG_CAM_UP:        cam_up_q       <= cfg_data_i[BASIS_REG_W-1:0];
        REG_FOCAL_LENGTH:  focal_q        <= cfg_data_i[FOCAL_W-1:0];
        REG_SCREEN_WIDTH:  width_q        <= cfg_data_i[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: height_q       <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  ppp_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .LW          (LW),
    .MAGW        (MAGW),
    .SQW         (SQW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .cam_position_i (cam_position_q),
    .cam_forward_i  (cam_forward_q),
    .cam_right_i    (cam_right_q),
    .cam_up_i       (cam_up_q),
    .valid_o        (fr_valid),
    .ready_i        (!mid_full),
    .depth_mag_o    (fr_depth),
    .x_mag_o        (fr_x),
    .y_mag_o        (fr_y),
    .sq_o           (fr_sq),
    .flags_o        (fr_flags)
  );

  assign mid_wdata = {fr_depth, fr_x, fr_y, fr_sq, fr_flags};

  ppp_fifo #(.WIDTH(MIDW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .full_o  (mid_full),
    .wdata_i (mid_wdata),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .rdata_o (mid_rdata)
  );

  ppp_back #(
    .MAGW (MAGW),
    .SQW  (SQW),
    .FRAC (SCREEN_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!mid_empty),
    .in_pop_o    (mid_pop),
    .depth_mag_i (mid_rdata[MIDW-1 -: MAGW]),
    .x_mag_i     (mid_rdata[MIDW-MAGW-1 -: MAGW]),
    .y_mag_i     (mid_rdata[MIDW-2*MAGW-1 -: MAGW]),
    .sq_i        (mid_rdata[FLW +: SQW]),
    .flags_i     (ppp_flags_t'(mid_rdata[FLW-1:0])),
    .focal_i     (focal_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_valid_o (bk_valid),
    .out_ready_i (!out_full),
    .screen_x_o  (bk_sx),
    .screen_y_o  (bk_sy),
    .distance_o  (bk_dist),
    .in_view_o   (bk_view)
  );

  assign out_wdata = {bk_sx, bk_sy, bk_dist, bk_view};

  ppp_fifo #(.WIDTH(OUTW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_valid),
    .full_o  (out_full),
    .wdata_i (out_wdata),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_rdata)
  );

  assign screen_x_o = $signed(out_rdata[OUTW-1 -: SCREEN_W]);
  assign screen_y_o = $signed(out_rdata[OUTW-SCREEN_W-1 -: SCREEN_W]);
  assign distance_o = out_rdata[DIST_W:1];
  assign in_view_o  = out_rdata[0];

endmodule
